// ===== sv/tuna_pkg.sv =====
package tuna_pkg;

    localparam int COORD_W         = 32;
    localparam int COORD_MAX       = 48;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NORM_FRAC       = 30;
    localparam int NORM_W          = 32;
    localparam int AREA_W          = 52;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } t_tri;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic        [AREA_W-1:0] tri_area;
        logic                     degenerate;
    } t_res;

endpackage

// ===== sv/triangle_unit_normal_and_area.sv =====
// Channel   Ports                       Handshake
// input     start, busy, i_item         taken when start is high and busy is low
// result    o_valid, o_result           one cycle per item, must be taken
//
// One item enters per cycle; busy never rises.
// Results pass through the registered front-end stages, the square-root
// pipeline (one root bit a stage), the 31-stage divider and an output register.
// Reset clears the valid bits only; there is no back-pressure on results.
module triangle_unit_normal_and_area #(
    parameter int COORD_WIDTH = tuna_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tuna_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  tuna_pkg::t_tri i_item,
    output logic           busy,
    output logic           o_valid,
    output tuna_pkg::t_res o_result
);
    import tuna_pkg::*;

    localparam int OW      = COORD_WIDTH + 1;
    localparam int HW      = (OW + 1) / 2;
    localparam int PW      = 2 * OW;
    localparam int LW      = (PW + 2) / 3;
    localparam int SW      = 2 * PW + 2;
    localparam int RW      = SW / 2;
    localparam int QW      = NORM_FRAC + 1;
    localparam int SIDE_SQ = 3 + 3 * PW;
    localparam int SIDE_DV = 3 + AREA_W + 1;

    localparam int PA [6] = '{1, 2, 2, 0, 0, 1};
    localparam int PB [6] = '{5, 4, 3, 5, 4, 3};

    function automatic logic [COORD_WIDTH-1:0] f_crd(input logic [COORD_W-1:0] f);
        logic [COORD_MAX-1:0] z;
        z = COORD_MAX'(f);
        return z[COORD_WIDTH-1:0];
    endfunction

    logic [8:0] r_vld;

    logic [5:0][OW-1:0]          r0_e;
    logic [5:0][OW-1:0]          r1_ma;
    logic [5:0][OW-1:0]          r1_mb;
    logic [5:0]                  r1_ng;
    logic [5:0][3:0][2*HW-1:0]   r2_pp;
    logic [5:0]                  r2_ng;
    logic [5:0][PW-1:0]          r3_p;
    logic [5:0]                  r3_ng;
    logic [2:0][PW:0]            r4_x;
    logic [2:0][PW-1:0]          r5_m;
    logic [2:0]                  r5_sg;
    logic [2:0][5:0][2*LW-1:0]   r6_pp;
    logic [2:0][PW-1:0]          r6_m;
    logic [2:0]                  r6_sg;
    logic [2:0][2*PW-1:0]        r7_q;
    logic [2:0][PW-1:0]          r7_m;
    logic [2:0]                  r7_sg;
    logic [SW-1:0]               r8_s;
    logic [2:0][PW-1:0]          r8_m;
    logic [2:0]                  r8_sg;
    t_res                        r_res;
    logic                        r_ovld;

    logic [5:0][OW-1:0]          n0_e;
    logic [5:0][OW-1:0]          n1_ma;
    logic [5:0][OW-1:0]          n1_mb;
    logic [5:0]                  n1_ng;
    logic [5:0][3:0][2*HW-1:0]   n2_pp;
    logic [5:0][PW-1:0]          n3_p;
    logic [2:0][PW:0]            n4_x;
    logic [2:0][PW-1:0]          n5_m;
    logic [2:0][5:0][2*LW-1:0]   n6_pp;
    logic [2:0][2*PW-1:0]        n7_q;
    logic [SW-1:0]               n8_s;
    t_res                        n_res;

    logic                        w_sq_vld;
    logic [RW-1:0]               w_root;
    logic [SIDE_SQ-1:0]          w_sq_side;
    logic [2:0]                  w_sq_sg;
    logic [2:0][PW-1:0]          w_sq_m;
    logic [RW+AREA_W-1:0]        w_ta;
    logic [AREA_W-1:0]           w_area;
    logic                        w_deg;
    logic                        w_dv_vld;
    logic [2:0][QW-1:0]          w_quo;
    logic [SIDE_DV-1:0]          w_dv_side;
    logic [2:0]                  w_dv_sg;
    logic [AREA_W-1:0]           w_dv_area;
    logic                        w_dv_deg;

    assign busy = 1'b0;

    always_comb begin
        logic [5:0][COORD_WIDTH-1:0] v;
        logic [2:0][COORD_WIDTH-1:0] a;
        v[0] = f_crd(i_item.bx);
        v[1] = f_crd(i_item.by_coord);
        v[2] = f_crd(i_item.bz);
        v[3] = f_crd(i_item.cx);
        v[4] = f_crd(i_item.cy);
        v[5] = f_crd(i_item.cz);
        a[0] = f_crd(i_item.ax);
        a[1] = f_crd(i_item.ay);
        a[2] = f_crd(i_item.az);
        n0_e[0] = {v[0][COORD_WIDTH-1], v[0]} - {a[0][COORD_WIDTH-1], a[0]};
        n0_e[1] = {v[1][COORD_WIDTH-1], v[1]} - {a[1][COORD_WIDTH-1], a[1]};
        n0_e[2] = {v[2][COORD_WIDTH-1], v[2]} - {a[2][COORD_WIDTH-1], a[2]};
        n0_e[3] = {v[3][COORD_WIDTH-1], v[3]} - {a[0][COORD_WIDTH-1], a[0]};
        n0_e[4] = {v[4][COORD_WIDTH-1], v[4]} - {a[1][COORD_WIDTH-1], a[1]};
        n0_e[5] = {v[5][COORD_WIDTH-1], v[5]} - {a[2][COORD_WIDTH-1], a[2]};
    end

    always_comb begin
        logic [OW-1:0] a;
        logic [OW-1:0] b;
        for (int j = 0; j < 6; j++) begin
            a        = r0_e[PA[j]];
            b        = r0_e[PB[j]];
            n1_ma[j] = a[OW-1] ? (~a + 1'b1) : a;
            n1_mb[j] = b[OW-1] ? (~b + 1'b1) : b;
            n1_ng[j] = a[OW-1] ^ b[OW-1];
        end
    end

    always_comb begin
        logic [2*HW-1:0] a;
        logic [2*HW-1:0] b;
        for (int j = 0; j < 6; j++) begin
            a           = (2*HW)'(r1_ma[j]);
            b           = (2*HW)'(r1_mb[j]);
            n2_pp[j][0] = (2*HW)'(a[HW-1:0])    * (2*HW)'(b[HW-1:0]);
            n2_pp[j][1] = (2*HW)'(a[HW-1:0])    * (2*HW)'(b[2*HW-1:HW]);
            n2_pp[j][2] = (2*HW)'(a[2*HW-1:HW]) * (2*HW)'(b[HW-1:0]);
            n2_pp[j][3] = (2*HW)'(a[2*HW-1:HW]) * (2*HW)'(b[2*HW-1:HW]);
        end
    end

    always_comb begin
        logic [4*HW-1:0] t;
        for (int j = 0; j < 6; j++) begin
            t = ((4*HW)'(r2_pp[j][3]) << (2*HW))
              + (((4*HW)'(r2_pp[j][1]) + (4*HW)'(r2_pp[j][2])) << HW)
              + (4*HW)'(r2_pp[j][0]);
            n3_p[j] = t[PW-1:0];
        end
    end

    always_comb begin
        logic [PW:0] s1;
        logic [PW:0] s2;
        for (int i = 0; i < 3; i++) begin
            s1      = r3_ng[2*i]   ? (~{1'b0, r3_p[2*i]} + 1'b1)   : {1'b0, r3_p[2*i]};
            s2      = r3_ng[2*i+1] ? (~{1'b0, r3_p[2*i+1]} + 1'b1) : {1'b0, r3_p[2*i+1]};
            n4_x[i] = s1 - s2;
        end
    end

    always_comb begin
        logic [PW:0] t;
        for (int i = 0; i < 3; i++) begin
            t       = r4_x[i][PW] ? (~r4_x[i] + 1'b1) : r4_x[i];
            n5_m[i] = t[PW-1:0];
        end
    end

    always_comb begin
        logic [3*LW-1:0] m;
        for (int i = 0; i < 3; i++) begin
            m           = (3*LW)'(r5_m[i]);
            n6_pp[i][0] = (2*LW)'(m[LW-1:0])      * (2*LW)'(m[LW-1:0]);
            n6_pp[i][1] = (2*LW)'(m[2*LW-1:LW])   * (2*LW)'(m[2*LW-1:LW]);
            n6_pp[i][2] = (2*LW)'(m[3*LW-1:2*LW]) * (2*LW)'(m[3*LW-1:2*LW]);
            n6_pp[i][3] = (2*LW)'(m[LW-1:0])      * (2*LW)'(m[2*LW-1:LW]);
            n6_pp[i][4] = (2*LW)'(m[LW-1:0])      * (2*LW)'(m[3*LW-1:2*LW]);
            n6_pp[i][5] = (2*LW)'(m[2*LW-1:LW])   * (2*LW)'(m[3*LW-1:2*LW]);
        end
    end

    always_comb begin
        logic [6*LW-1:0] t;
        for (int i = 0; i < 3; i++) begin
            t = ((6*LW)'(r6_pp[i][2]) << (4*LW))
              + ((6*LW)'(r6_pp[i][5]) << (3*LW+1))
              + ((6*LW)'(r6_pp[i][1]) << (2*LW))
              + ((6*LW)'(r6_pp[i][4]) << (2*LW+1))
              + ((6*LW)'(r6_pp[i][3]) << (LW+1))
              + (6*LW)'(r6_pp[i][0]);
            n7_q[i] = t[2*PW-1:0];
        end
    end

    assign n8_s = SW'(r7_q[0]) + SW'(r7_q[1]) + SW'(r7_q[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r0_e  <= n0_e;
        r1_ma <= n1_ma;
        r1_mb <= n1_mb;
        r1_ng <= n1_ng;
        r2_pp <= n2_pp;
        r2_ng <= r1_ng;
        r3_p  <= n3_p;
        r3_ng <= r2_ng;
        r4_x  <= n4_x;
        r5_m  <= n5_m;
        r5_sg <= {r4_x[2][PW], r4_x[1][PW], r4_x[0][PW]};
        r6_pp <= n6_pp;
        r6_m  <= r5_m;
        r6_sg <= r5_sg;
        r7_q  <= n7_q;
        r7_m  <= r6_m;
        r7_sg <= r6_sg;
        r8_s  <= n8_s;
        r8_m  <= r7_m;
        r8_sg <= r7_sg;
    end

    tuna_isqrt #(
        .SW     (SW),
        .SIDE_W (SIDE_SQ)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[8]),
        .i_rad   (r8_s),
        .i_side  ({r8_sg, r8_m}),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    assign {w_sq_sg, w_sq_m} = w_sq_side;

    assign w_ta   = {{AREA_W{1'b0}}, w_root} >> (FRAC_BITS + 1);
    assign w_area = (|w_ta[RW+AREA_W-1:AREA_W]) ? {AREA_W{1'b1}} : w_ta[AREA_W-1:0];
    assign w_deg  = (w_root == '0);

    tuna_div #(
        .NW     (PW),
        .DW     (RW),
        .SIDE_W (SIDE_DV)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_vld),
        .i_num   (w_sq_m),
        .i_den   (w_root),
        .i_side  ({w_sq_sg, w_area, w_deg}),
        .o_valid (w_dv_vld),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    assign {w_dv_sg, w_dv_area, w_dv_deg} = w_dv_side;

    always_comb begin
        logic [2:0][NORM_W-1:0] nv;
        logic [NORM_W-1:0]      qe;
        for (int l = 0; l < 3; l++) begin
            qe    = NORM_W'(w_quo[l]);
            nv[l] = w_dv_deg ? '0 : (w_dv_sg[l] ? (~qe + 1'b1) : qe);
        end
        n_res.normal_x   = nv[0];
        n_res.normal_y   = nv[1];
        n_res.normal_z   = nv[2];
        n_res.tri_area   = w_dv_area;
        n_res.degenerate = w_dv_deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_ovld;
    assign o_result = r_res;

endmodule

// ===== sv/tuna_isqrt.sv =====
module tuna_isqrt #(
    parameter int SW     = 134,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SW-1:0]     i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [SW/2-1:0]   o_root,
    output logic [SIDE_W-1:0] o_side
);
    import tuna_pkg::*;

    localparam int RW = SW / 2;

    logic              r_vld  [RW];
    logic [SW-1:0]     r_rad  [RW];
    logic [RW+1:0]     r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [SIDE_W-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stg
        logic              v_in;
        logic [SW-1:0]     rad_in;
        logic [RW+1:0]     rem_in;
        logic [RW-1:0]     root_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW+3:0]     rem_sh;
        logic [RW+3:0]     trial;
        logic [RW+3:0]     diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        assign rem_sh = {rem_in, rad_in[SW-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);
        assign diff   = rem_sh - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[k]  <= {rad_in[SW-3:0], 2'b00};
            r_rem[k]  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
            r_root[k] <= {root_in[RW-2:0], ge};
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// ===== sv/tuna_div.sv =====
module tuna_div #(
    parameter int NW     = 66,
    parameter int DW     = 67,
    parameter int SIDE_W = 56
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [2:0][NW-1:0]                i_num,
    input  logic [DW-1:0]                     i_den,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic [2:0][tuna_pkg::NORM_FRAC:0] o_quo,
    output logic [SIDE_W-1:0]                 o_side
);
    import tuna_pkg::*;

    localparam int QS = NORM_FRAC + 1;

    logic                 r_vld  [QS];
    logic [2:0][DW:0]     r_rem  [QS];
    logic [2:0][QS-1:0]   r_quo  [QS];
    logic [DW-1:0]        r_den  [QS];
    logic [SIDE_W-1:0]    r_side [QS];

    for (genvar k = 0; k < QS; k++) begin : g_stg
        logic               v_in;
        logic [2:0][DW:0]   rem_in;
        logic [2:0][QS-1:0] quo_in;
        logic [DW-1:0]      den_in;
        logic [SIDE_W-1:0]  side_in;
        logic [2:0][DW:0]   n_rem;
        logic [2:0][QS-1:0] n_quo;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign quo_in  = '0;
            for (genvar l = 0; l < 3; l++) begin : g_ln
                assign rem_in[l] = (DW+1)'(i_num[l]);
            end
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign quo_in  = r_quo[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            logic [DW:0] sub;
            logic        ge;
            for (int l = 0; l < 3; l++) begin
                ge       = (rem_in[l] >= {1'b0, den_in});
                sub      = ge ? (rem_in[l] - {1'b0, den_in}) : rem_in[l];
                n_rem[l] = {sub[DW-1:0], 1'b0};
                n_quo[l] = {quo_in[l][QS-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_quo[k]  <= n_quo;
            r_den[k]  <= den_in;
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[QS-1];
    assign o_quo   = r_quo[QS-1];
    assign o_side  = r_side[QS-1];

endmodule
